// ===== sv/str_pkg.sv =====
// shared types, constants and helpers of the stepper trapezoid ramp generator
package str_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int SPEED_WIDTH = 16;
    localparam int STEPS_WIDTH = 24;
    localparam int KIND_WIDTH  = 2;
    localparam int PHASE_WIDTH = 2;

    localparam logic [SPEED_WIDTH-1:0] START_SPEED_RESET = SPEED_WIDTH'(200);
    localparam logic [SPEED_WIDTH-1:0] FULL_SPEED_RESET  = SPEED_WIDTH'(2000);
    localparam logic [SPEED_WIDTH-1:0] SPEED_STEP        = SPEED_WIDTH'(2);

    // n / 10 for n below 2**26 as (n * ceil(2**27 / 10)) >> 27
    localparam int                     DIV10_SHIFT = 27;
    localparam logic [STEPS_WIDTH-1:0] DIV10_MAGIC = STEPS_WIDTH'(24'hCCCCCD);
    localparam int                     PROD_WIDTH  = 2 * STEPS_WIDTH;
    localparam int                     TENTH_WIDTH = PROD_WIDTH - DIV10_SHIFT;

    localparam logic [KIND_WIDTH-1:0] KIND_START = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_STEP  = 2'd2;

    localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_STOP  = 2'd0;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_ACCEL = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_RUN   = 2'd2;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_DECEL = 2'd3;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_SPEED = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FULL_SPEED  = 1'b1;

    typedef enum logic [3:0] {
        PH_STOP  = 4'b0001,
        PH_ACCEL = 4'b0010,
        PH_RUN   = 4'b0100,
        PH_DECEL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [COUNT_WIDTH-1:0] ramp_limit;
        logic [COUNT_WIDTH-1:0] run_limit;
    } str_request_t;

    typedef struct packed {
        logic                   ramp_clock_on;
        logic                   step_clock_on;
        logic [PHASE_WIDTH-1:0] phase;
        logic [SPEED_WIDTH-1:0] speed_pps;
    } str_result_t;

    function automatic logic [TENTH_WIDTH-1:0] div10(input logic [STEPS_WIDTH-1:0] n);
        logic [PROD_WIDTH-1:0] prod;
        prod = {{STEPS_WIDTH{1'b0}}, n} * {{STEPS_WIDTH{1'b0}}, DIV10_MAGIC};
        return prod[PROD_WIDTH-1:DIV10_SHIFT];
    endfunction

    function automatic logic [PHASE_WIDTH-1:0] phase_code(input phase_t ph);
        logic [PHASE_WIDTH-1:0] code;
        unique case (ph)
            PH_STOP:  code = PHASE_CODE_STOP;
            PH_ACCEL: code = PHASE_CODE_ACCEL;
            PH_RUN:   code = PHASE_CODE_RUN;
            PH_DECEL: code = PHASE_CODE_DECEL;
            default:  code = PHASE_CODE_STOP;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/stepper_trapezoid_ramp_top.sv =====
// top level of the trapezoid stepper ramp generator: stream ports, config, pipeline
// path from request accept to result valid: input register, then result register
// throughput: one request per cycle unless m_tready stalls; the limit divide is in front of
// the input register and the whole move update is one pass between input and result regs
// reset: synchronous active low; phase stop, speed and counters zero, both clocks off,
// start_speed 200 and full_speed 2000
module stepper_trapezoid_ramp_top
    import str_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // kind[1:0], move_steps[25:2], zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // speed_pps[15:0], phase[17:16],
                                                  // step_clock_on[18], ramp_clock_on[19], zero
    input  logic                       cfg_wen,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SPEED_WIDTH-1:0]     cfg_wdata
);

    logic [SPEED_WIDTH-1:0] start_speed_reg;
    logic [SPEED_WIDTH-1:0] full_speed_reg;

    logic                   in_valid_reg;
    str_request_t           req_reg, req_next;
    logic                   out_valid_reg;
    str_result_t            result_reg, result_next;

    logic                   out_free;
    logic                   fire;
    logic                   s_accept;
    logic [STEPS_WIDTH-1:0] move_steps;
    logic [TENTH_WIDTH-1:0] tenth;
    logic [COUNT_WIDTH+2:0] run_sum;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign move_steps = s_tdata[KIND_WIDTH +: STEPS_WIDTH];
    assign tenth      = div10(move_steps);
    assign run_sum    = ((COUNT_WIDTH+3)'(tenth) << 2) + ((COUNT_WIDTH+3)'(tenth) << 1);

    always_comb begin
        req_next.kind       = s_tdata[KIND_WIDTH-1:0];
        req_next.ramp_limit = COUNT_WIDTH'({tenth, 1'b0});
        req_next.run_limit  = run_sum[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_speed_reg <= START_SPEED_RESET;
            full_speed_reg  <= FULL_SPEED_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_START_SPEED: start_speed_reg <= cfg_wdata;
                CFG_FULL_SPEED:  full_speed_reg  <= cfg_wdata;
                default:         start_speed_reg <= start_speed_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= req_next;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    str_ramp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req         (req_reg),
        .start_speed (start_speed_reg),
        .full_speed  (full_speed_reg),
        .result_next (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg};

`ifndef SYNTHESIS
    a_ready_when_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_request_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed request produced no result");

    a_result_held_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
`endif

endmodule

// ===== sv/str_ramp_core.sv =====
// move state and per-request update of the trapezoid ramp profiler
module str_ramp_core
    import str_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  str_request_t           req,
    input  logic [SPEED_WIDTH-1:0] start_speed,
    input  logic [SPEED_WIDTH-1:0] full_speed,
    output str_result_t            result_next
);

    phase_t                 phase_reg, phase_next;
    logic [SPEED_WIDTH-1:0] speed_reg, speed_next;
    logic [COUNT_WIDTH-1:0] run_cnt_reg, run_cnt_next;
    logic [COUNT_WIDTH-1:0] ramp_cnt_reg, ramp_cnt_next;
    logic [COUNT_WIDTH-1:0] ramp_limit_reg, ramp_limit_next;
    logic [COUNT_WIDTH-1:0] run_limit_reg, run_limit_next;
    logic                   step_on_reg, step_on_next;
    logic                   ramp_on_reg, ramp_on_next;

    logic [SPEED_WIDTH:0]   speed_up;
    logic [SPEED_WIDTH-1:0] speed_up_sat;
    logic [SPEED_WIDTH-1:0] speed_down_sat;
    logic [COUNT_WIDTH:0]   ramp_cnt_plus;
    logic [COUNT_WIDTH-1:0] ramp_cnt_inc;
    logic [COUNT_WIDTH-1:0] run_cnt_inc;

    assign speed_up       = {1'b0, speed_reg} + {1'b0, SPEED_STEP};
    assign speed_up_sat   = speed_up[SPEED_WIDTH] ? '1 : speed_up[SPEED_WIDTH-1:0];
    assign speed_down_sat = (speed_reg >= SPEED_STEP) ? speed_reg - SPEED_STEP : '0;
    assign ramp_cnt_plus  = {1'b0, ramp_cnt_reg} + (COUNT_WIDTH+1)'(1);
    assign ramp_cnt_inc   = (&ramp_cnt_reg) ? ramp_cnt_reg : ramp_cnt_plus[COUNT_WIDTH-1:0];
    assign run_cnt_inc    = (&run_cnt_reg) ? run_cnt_reg : run_cnt_reg + COUNT_WIDTH'(1);

    always_comb begin
        phase_next      = phase_reg;
        speed_next      = speed_reg;
        run_cnt_next    = run_cnt_reg;
        ramp_cnt_next   = ramp_cnt_reg;
        ramp_limit_next = ramp_limit_reg;
        run_limit_next  = run_limit_reg;
        step_on_next    = step_on_reg;
        ramp_on_next    = ramp_on_reg;
        unique case (req.kind)
            KIND_START: begin
                phase_next      = PH_ACCEL;
                speed_next      = start_speed;
                ramp_limit_next = req.ramp_limit;
                run_limit_next  = req.run_limit;
                run_cnt_next    = '0;
                ramp_cnt_next   = '0;
                step_on_next    = 1'b1;
                ramp_on_next    = 1'b1;
            end
            KIND_TICK: begin
                if (ramp_on_reg) begin
                    unique case (phase_reg)
                        PH_ACCEL: begin
                            speed_next = (speed_reg < full_speed) ? speed_up_sat : full_speed;
                            if (ramp_cnt_plus >= {1'b0, ramp_limit_reg}) begin
                                phase_next = PH_RUN;
                            end
                        end
                        PH_DECEL: begin
                            speed_next = (speed_reg > start_speed) ? speed_down_sat
                                                                   : start_speed;
                            if (ramp_cnt_reg >= ramp_limit_reg) begin
                                phase_next   = PH_STOP;
                                step_on_next = 1'b0;
                            end
                        end
                        default: begin
                            ramp_on_next = 1'b0;
                        end
                    endcase
                end
            end
            KIND_STEP: begin
                if (step_on_reg) begin
                    unique case (phase_reg)
                        PH_RUN: begin
                            if (run_cnt_reg >= run_limit_reg) begin
                                phase_next    = PH_DECEL;
                                ramp_on_next  = 1'b1;
                                ramp_cnt_next = '0;
                            end else begin
                                run_cnt_next = run_cnt_inc;
                            end
                        end
                        PH_ACCEL, PH_DECEL: begin
                            ramp_cnt_next = ramp_cnt_inc;
                        end
                        default: begin
                            ramp_cnt_next = ramp_cnt_reg;
                        end
                    endcase
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_STOP;
            speed_reg      <= '0;
            run_cnt_reg    <= '0;
            ramp_cnt_reg   <= '0;
            ramp_limit_reg <= '0;
            run_limit_reg  <= '0;
            step_on_reg    <= 1'b0;
            ramp_on_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            speed_reg      <= speed_next;
            run_cnt_reg    <= run_cnt_next;
            ramp_cnt_reg   <= ramp_cnt_next;
            ramp_limit_reg <= ramp_limit_next;
            run_limit_reg  <= run_limit_next;
            step_on_reg    <= step_on_next;
            ramp_on_reg    <= ramp_on_next;
        end
    end

    assign result_next.speed_pps     = speed_next;
    assign result_next.phase         = phase_code(phase_next);
    assign result_next.step_clock_on = step_on_next;
    assign result_next.ramp_clock_on = ramp_on_next;

`ifndef SYNTHESIS
    a_step_off_only_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_on_reg |-> phase_reg == PH_STOP)
        else $error("step clock off outside stop phase");

    a_run_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        run_cnt_reg <= run_limit_reg)
        else $error("run step count beyond run limit");

    a_start_loads_move: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.kind == KIND_START |=>
            phase_reg == PH_ACCEL && speed_reg == $past(start_speed)
            && step_on_reg && ramp_on_reg && ramp_cnt_reg == '0)
        else $error("start request did not load the move");
`endif

endmodule
